// ----- design/sound_frame_sequencer_control_assert.svh -----
// ------------------------------------------------------------------------
// sound_frame_sequencer_control_assert.svh
// assertion macros shared by the sound controller rtl
// ------------------------------------------------------------------------
`ifndef SOUND_FRAME_SEQUENCER_CONTROL_ASSERT_SVH
`define SOUND_FRAME_SEQUENCER_CONTROL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SFSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sfsc_pkg.sv -----
// ------------------------------------------------------------------------
// sfsc_pkg
// shared types and constants of the sound controller core
// ------------------------------------------------------------------------
package sfsc_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    // register offsets
    localparam logic [3:0] REG_VOLUME = 4'd0;
    localparam logic [3:0] REG_PAN    = 4'd1;
    localparam logic [3:0] REG_MASTER = 4'd2;

    // read-back constants
    localparam logic [7:0] STATUS_FILL = 8'h70;
    localparam logic [7:0] UNUSED_READ = 8'hFF;
    localparam int         MASTER_BIT  = 7;
    localparam int         STATUS_CHANNELS = 4;

    // field widths
    localparam int LEN_IN_BITS = 9;
    localparam int S_DATA_BITS = 32;
    localparam int M_DATA_BITS = 32;

    // parameter defaults
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int LENGTH_BITS_DEF  = 9;

endpackage

// ----- design/sound_frame_sequencer_control.sv -----
// ------------------------------------------------------------------------
// sound_frame_sequencer_control
// four-channel sound controller core: master, volume and pan registers,
// status read-back, frame sequencer and per-channel length counters
// ------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  s_       | in  | s_tvalid/s_tready | s_tuser command, s_tdata operands
//  m_       | out | m_tvalid/m_tready | m_tdata result (one per request)
//
//  every request updates the state at the accepting edge and its result
//  lands in the output register there
//  a new request is taken each cycle while the output register is empty
//  or being drained, so the rate is one request per clock
//  a stalled m_ side holds the result and pulls s_tready low
//  aresetn (synchronous, active low) clears all state and the output valid
// ------------------------------------------------------------------------
`include "sound_frame_sequencer_control_assert.svh"

module sound_frame_sequencer_control #(
    parameter int NUM_CHANNELS = sfsc_pkg::NUM_CHANNELS_DEF,
    parameter int LENGTH_BITS  = sfsc_pkg::LENGTH_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] reg_index, [11:4] write_data, [13:12] channel_select,
    // [22:14] length_value, [23] length_enable_in, [24] channel_on, rest zero
    input  logic [sfsc_pkg::S_DATA_BITS-1:0] s_tdata,
    // [1:0] command
    input  sfsc_pkg::cmd_t                  s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] read_data, [10:8] volume_left_out, [13:11] volume_right_out,
    // [21:14] pan_out, [25:22] channel_status, [26] master_on,
    // [27] sweep_pulse, [28] envelope_pulse, [29] clear_channel_regs,
    // rest zero
    output logic [sfsc_pkg::M_DATA_BITS-1:0] m_tdata
);
    import sfsc_pkg::*;

    // wide enough to compare an incoming length against the counter max
    localparam int LW = (LENGTH_BITS > LEN_IN_BITS) ? LENGTH_BITS : LEN_IN_BITS;
    localparam logic [LW-1:0] LEN_MAX_W = LW'((1 << LENGTH_BITS) - 1);

    // unpacked request fields
    logic [3:0]             reg_index;
    logic [7:0]             write_data;
    logic [1:0]             channel_select;
    logic [LEN_IN_BITS-1:0] length_value;
    logic                   length_enable_in;
    logic                   channel_on;

    assign reg_index        = s_tdata[3:0];
    assign write_data       = s_tdata[11:4];
    assign channel_select   = s_tdata[13:12];
    assign length_value     = s_tdata[22:14];
    assign length_enable_in = s_tdata[23];
    assign channel_on       = s_tdata[24];

    // controller state
    logic                   master_reg,  master_next;
    logic [2:0]             vol_left_reg, vol_left_next;
    logic [2:0]             vol_right_reg, vol_right_next;
    logic [7:0]             pan_reg,     pan_next;
    logic [3:0]             chan_status_reg, chan_status_next;
    logic [2:0]             step_reg,    step_next;
    logic [LENGTH_BITS-1:0] len_cnt_reg  [NUM_CHANNELS];
    logic [LENGTH_BITS-1:0] len_cnt_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] len_en_reg, len_en_next;

    // output register
    logic                   out_valid_reg;
    logic [M_DATA_BITS-1:0] out_data_reg, out_data_next;

    // per-request result flags
    logic [7:0]             rd_data;
    logic                   sweep;
    logic                   envelope;
    logic                   clear_regs;
    logic [LENGTH_BITS-1:0] len_sat;
    logic [LW-1:0]          len_wide;
    logic                   s_fire;

    // output register is free when empty or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // loads above the counter range saturate to all ones
    assign len_wide = LW'(length_value);
    assign len_sat  = (len_wide > LEN_MAX_W) ? '1 : LENGTH_BITS'(len_wide);

    // request decode and state update
    always_comb begin
        master_next      = master_reg;
        vol_left_next    = vol_left_reg;
        vol_right_next   = vol_right_reg;
        pan_next         = pan_reg;
        chan_status_next = chan_status_reg;
        step_next        = step_reg;
        len_cnt_next     = len_cnt_reg;
        len_en_next      = len_en_reg;
        rd_data          = '0;
        sweep            = 1'b0;
        envelope         = 1'b0;
        clear_regs       = 1'b0;

        if (s_fire) begin
            case (s_tuser)
                CMD_WRITE: begin
                    case (reg_index)
                        REG_VOLUME: begin
                            // ignored while master is off
                            if (master_reg) begin
                                vol_left_next  = write_data[6:4];
                                vol_right_next = write_data[2:0];
                                rd_data        = write_data;
                            end
                        end
                        REG_PAN: begin
                            if (master_reg) begin
                                pan_next = write_data;
                                rd_data  = write_data;
                            end
                        end
                        REG_MASTER: begin
                            // master off wipes the mix registers, even if already off
                            if (!write_data[MASTER_BIT]) begin
                                vol_left_next    = '0;
                                vol_right_next   = '0;
                                pan_next         = '0;
                                chan_status_next = '0;
                                clear_regs       = 1'b1;
                            end
                            master_next = write_data[MASTER_BIT];
                        end
                        default: begin
                            rd_data = UNUSED_READ;
                        end
                    endcase
                end
                CMD_READ: begin
                    rd_data = STATUS_FILL | {master_reg, 7'd0} | {4'd0, chan_status_reg};
                end
                CMD_TICK: begin
                    step_next = step_reg + 3'd1;
                    // even steps clock the length counters
                    if (!step_next[0]) begin
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (len_en_reg[c] && (len_cnt_reg[c] != '0)) begin
                                len_cnt_next[c] = len_cnt_reg[c] - LENGTH_BITS'(1);
                                if ((len_cnt_reg[c] == LENGTH_BITS'(1)) &&
                                    (c < STATUS_CHANNELS)) begin
                                    chan_status_next[2'(c)] = 1'b0;
                                end
                            end
                        end
                    end
                    sweep    = (step_next == 3'd2) || (step_next == 3'd6);
                    envelope = (step_next == 3'd7);
                end
                CMD_LOAD: begin
                    // selects beyond the channel count fall through every compare
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (int'(channel_select) == c) begin
                            len_cnt_next[c] = len_sat;
                            len_en_next[c]  = length_enable_in;
                            if (channel_on && (c < STATUS_CHANNELS)) begin
                                chan_status_next[2'(c)] = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    rd_data = '0;
                end
            endcase
        end
    end

    // result word, reporting state after the request
    always_comb begin
        out_data_next = {2'd0, clear_regs, envelope, sweep, master_next,
                         chan_status_next, pan_next, vol_right_next, vol_left_next,
                         rd_data};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg      <= 1'b0;
            vol_left_reg    <= '0;
            vol_right_reg   <= '0;
            pan_reg         <= '0;
            chan_status_reg <= '0;
            step_reg        <= '0;
            len_en_reg      <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                len_cnt_reg[c] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            master_reg      <= master_next;
            vol_left_reg    <= vol_left_next;
            vol_right_reg   <= vol_right_next;
            pan_reg         <= pan_next;
            chan_status_reg <= chan_status_next;
            step_reg        <= step_next;
            len_en_reg      <= len_en_next;
            len_cnt_reg     <= len_cnt_next;
            if (s_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // sweep on steps 2 and 6, envelope on step 7: never together
    `SFSC_ASSERT_NOW(a_pulse_excl, aclk, aresetn, m_tvalid,
        !(m_tdata[27] && m_tdata[28]), "sweep and envelope pulses in one result")

    // a clear pulse reports master, pan and status all cleared
    `SFSC_ASSERT_NOW(a_clear_state, aclk, aresetn, m_tvalid && m_tdata[29],
        (m_tdata[26] == 1'b0) && (m_tdata[21:14] == 8'd0) && (m_tdata[25:22] == 4'd0),
        "clear pulse with live mix state")

    // each accepted tick moves the sequencer one step
    `SFSC_ASSERT_NEXT(a_step_adv, aclk, aresetn, s_fire && (s_tuser == CMD_TICK),
        step_reg == 3'($past(step_reg) + 3'd1), "sequencer step did not advance")

    // volume writes have no effect while master is off
    `SFSC_ASSERT_NEXT(a_vol_locked, aclk, aresetn,
        s_fire && (s_tuser == CMD_WRITE) && (reg_index == REG_VOLUME) && !master_reg,
        (vol_left_reg == $past(vol_left_reg)) && (vol_right_reg == $past(vol_right_reg)),
        "volume changed with master off")

endmodule

// ----- sim/tb_sound_frame_sequencer_control.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_sound_frame_sequencer_control
// self-checking bench for the sound controller core: requests go in on
// the s_ stream and every result on the m_ stream is compared field by
// field against a cycle-free predictor of the registers, the frame
// sequencer and the length counters, under random gaps and stalls
// ------------------------------------------------------------------------
module tb_sound_frame_sequencer_control;
    import sfsc_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int LEN_BITS    = LENGTH_BITS_DEF;
    localparam int LEN_MAX     = (1 << LEN_BITS) - 1;
    localparam int CYCLE_LIMIT = 400000;

    // one request as the bench sees it
    typedef struct packed {
        cmd_t                   cmd;
        logic [3:0]             reg_index;
        logic [7:0]             wr_data;
        logic [1:0]             chan;
        logic [LEN_IN_BITS-1:0] len_value;
        logic                   len_en;
        logic                   chan_on;
    } sound_req_t;

    // one result, state after the request plus the pulses it caused
    typedef struct packed {
        logic [7:0] rd;
        logic [2:0] vol_left;
        logic [2:0] vol_right;
        logic [7:0] pan;
        logic [3:0] status;
        logic       master;
        logic       sweep;
        logic       env;
        logic       clr;
    } sound_resp_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata  = '0;
    cmd_t                    s_tuser  = CMD_WRITE;
    logic                    m_tvalid;
    logic                    m_tready = 1'b1;
    logic [M_DATA_BITS-1:0]  m_tdata;

    // predicted controller state
    logic                snd_master = 1'b0;
    logic [2:0]          snd_vol_left = '0;
    logic [2:0]          snd_vol_right = '0;
    logic [7:0]          snd_pan = '0;
    logic [3:0]          snd_status = '0;
    logic [2:0]          seq_step = '0;
    logic [LEN_BITS-1:0] len_count [NUM_CH] = '{default: '0};
    logic                len_enable [NUM_CH] = '{default: 1'b0};

    // results still owed by the block, oldest first
    sound_resp_t pending_responses [$];
    sound_resp_t want_resp;

    int fail_count  = 0;
    int cycle_count = 0;

    // sender and receiver pacing knobs
    int tx_gap_max    = 0;
    int tx_burst_left = 0;
    int rx_mode       = 0;
    int rx_hold_off   = 0;
    int rx_phase      = 0;

    sound_frame_sequencer_control dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** sound_frame_sequencer_control: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor: applies one request to the shadow state and returns the
    // result the block must produce for it
    // ------------------------------------------------------------------
    function automatic sound_resp_t predict_sound_response(sound_req_t rq);
        sound_resp_t r;
        logic [2:0]  next_step;
        r = '0;
        case (rq.cmd)
            CMD_WRITE: begin
                if (rq.reg_index == REG_VOLUME) begin
                    // ignored while master is off
                    if (snd_master) begin
                        snd_vol_left  = rq.wr_data[6:4];
                        snd_vol_right = rq.wr_data[2:0];
                        r.rd = rq.wr_data;
                    end
                end else if (rq.reg_index == REG_PAN) begin
                    if (snd_master) begin
                        snd_pan = rq.wr_data;
                        r.rd = rq.wr_data;
                    end
                end else if (rq.reg_index == REG_MASTER) begin
                    // master off wipes volume, pan and status, even when already off
                    if (!rq.wr_data[MASTER_BIT]) begin
                        snd_vol_left  = '0;
                        snd_vol_right = '0;
                        snd_pan       = '0;
                        snd_status    = '0;
                        r.clr = 1'b1;
                    end
                    snd_master = rq.wr_data[MASTER_BIT];
                end else begin
                    r.rd = UNUSED_READ;
                end
            end
            CMD_READ: begin
                r.rd = {snd_master, 7'b0} | STATUS_FILL | {4'b0, snd_status};
            end
            CMD_TICK: begin
                next_step = seq_step + 3'd1;
                // even steps clock the length counters, a counter at zero holds
                if (!next_step[0]) begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (len_enable[ch] && len_count[ch] != '0) begin
                            len_count[ch] = len_count[ch] - 1'b1;
                            if (len_count[ch] == '0 && ch < STATUS_CHANNELS)
                                snd_status[ch] = 1'b0;
                        end
                    end
                end
                // sweep on steps 2 and 6, envelope on step 7
                r.sweep = (next_step == 3'd2) || (next_step == 3'd6);
                r.env   = (next_step == 3'd7);
                seq_step = next_step;
            end
            CMD_LOAD: begin
                // taken regardless of master, oversized loads saturate
                if (rq.chan < NUM_CH) begin
                    len_count[rq.chan]  = (rq.len_value > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0]
                                                                   : rq.len_value;
                    len_enable[rq.chan] = rq.len_en;
                    if (rq.chan_on && rq.chan < STATUS_CHANNELS)
                        snd_status[rq.chan] = 1'b1;
                end
            end
            default: begin
                r.rd = '0;
            end
        endcase
        r.vol_left  = snd_vol_left;
        r.vol_right = snd_vol_right;
        r.pan       = snd_pan;
        r.status    = snd_status;
        r.master    = snd_master;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: offers one request, honoring the burst/gap pattern, and
    // books the expected result once the block takes it
    // ------------------------------------------------------------------
    task automatic send_request(input sound_req_t rq);
        int gap;
        if (tx_gap_max > 0) begin
            if (tx_burst_left == 0) begin
                gap = $urandom_range(1, tx_gap_max);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                tx_burst_left = $urandom_range(1, 24);
            end
            tx_burst_left--;
        end
        s_tuser  <= rq.cmd;
        s_tdata  <= {7'b0, rq.chan_on, rq.len_en, rq.len_value, rq.chan,
                     rq.wr_data, rq.reg_index};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_responses.push_back(predict_sound_response(rq));
    endtask

    // drop valid and hold until every booked result has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
    endtask

    function automatic sound_req_t make_request(cmd_t cmd, logic [3:0] reg_index,
                                                logic [7:0] wr_data, logic [1:0] chan,
                                                logic [LEN_IN_BITS-1:0] len_value,
                                                logic len_en, logic chan_on);
        sound_req_t rq;
        rq.cmd       = cmd;
        rq.reg_index = reg_index;
        rq.wr_data   = wr_data;
        rq.chan      = chan;
        rq.len_value = len_value;
        rq.len_en    = len_en;
        rq.chan_on   = chan_on;
        return rq;
    endfunction

    // mostly well-formed traffic with master on, short lengths so that
    // counters run out often, and every field filled with noise first
    function automatic sound_req_t random_request();
        sound_req_t rq;
        int         pick;
        int         sub;
        rq.cmd       = CMD_READ;
        rq.reg_index = 4'($urandom);
        rq.wr_data   = 8'($urandom);
        rq.chan      = 2'($urandom);
        rq.len_value = LEN_IN_BITS'($urandom);
        rq.len_en    = 1'($urandom);
        rq.chan_on   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            rq.cmd = CMD_WRITE;
            sub = $urandom_range(0, 99);
            if (sub < 35) begin
                rq.reg_index = REG_VOLUME;
            end else if (sub < 65) begin
                rq.reg_index = REG_PAN;
            end else if (sub < 85) begin
                rq.reg_index = REG_MASTER;
                rq.wr_data[MASTER_BIT] = ($urandom_range(0, 9) != 0);
            end else begin
                rq.reg_index = 4'($urandom_range(REG_MASTER + 1, 15));
            end
        end else if (pick < 45) begin
            rq.cmd = CMD_READ;
        end else if (pick < 80) begin
            rq.cmd = CMD_TICK;
        end else begin
            rq.cmd = CMD_LOAD;
            if ($urandom_range(0, 3) != 0)
                rq.len_value = LEN_IN_BITS'($urandom_range(0, 12));
            rq.len_en  = ($urandom_range(0, 4) != 0);
            rq.chan_on = ($urandom_range(0, 4) != 0);
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // receiver: m_tready pattern, with a long hold-off when asked
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_phase++;
        if (rx_hold_off > 0) begin
            m_tready <= 1'b0;
            rx_hold_off--;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((rx_phase % 8) < 5);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // result checker: every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_responses.size() == 0) begin
                $error("result 0x%0h with no request outstanding", m_tdata);
                fail_count++;
            end else begin
                want_resp = pending_responses.pop_front();
                check_field("read_data",          want_resp.rd,        m_tdata[7:0]);
                check_field("volume_left_out",    want_resp.vol_left,  m_tdata[10:8]);
                check_field("volume_right_out",   want_resp.vol_right, m_tdata[13:11]);
                check_field("pan_out",            want_resp.pan,       m_tdata[21:14]);
                check_field("channel_status",     want_resp.status,    m_tdata[25:22]);
                check_field("master_on",          want_resp.master,    m_tdata[26]);
                check_field("sweep_pulse",        want_resp.sweep,     m_tdata[27]);
                check_field("envelope_pulse",     want_resp.env,       m_tdata[28]);
                check_field("clear_channel_regs", want_resp.clr,       m_tdata[29]);
                check_field("m_tdata padding",    0, m_tdata[M_DATA_BITS-1:30]);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register writes on and off, status read, unused offsets
    task automatic test_register_access();
        // master is off after reset: read shows fill only, writes bounce
        send_request(make_request(CMD_READ,  4'hF,       8'hFF, 2'd3, 9'h1FF, 1'b1, 1'b1));
        send_request(make_request(CMD_WRITE, REG_VOLUME, 8'hFF, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_PAN,    8'hFF, 2'd0, 9'd0,   1'b0, 1'b0));
        // master off while already off still pulses the clear
        send_request(make_request(CMD_WRITE, REG_MASTER, 8'h00, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_MASTER, 8'h80, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_VOLUME, 8'hFF, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_VOLUME, 8'h00, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_PAN,    8'hFF, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_PAN,    8'h00, 2'd0, 9'd0,   1'b0, 1'b0));
        // offsets past master, up to the top of the field
        send_request(make_request(CMD_WRITE, 4'd3,       8'h5A, 2'd0, 9'd0,   1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, 4'd15,      8'hA5, 2'd0, 9'd0,   1'b0, 1'b0));
    endtask

    // length loads, counter expiry and holding at zero, a full step cycle
    task automatic test_length_counters();
        send_request(make_request(CMD_LOAD, 4'd0, 8'd0, 2'd0, 9'd1,   1'b1, 1'b1));
        // zero length with counting on: holds, status stays set
        send_request(make_request(CMD_LOAD, 4'd0, 8'd0, 2'd1, 9'd0,   1'b1, 1'b1));
        // maximum length, status left alone
        send_request(make_request(CMD_LOAD, 4'd0, 8'd0, 2'd2, 9'h1FF, 1'b1, 1'b0));
        // counting disabled: never expires
        send_request(make_request(CMD_LOAD, 4'd0, 8'd0, 2'd3, 9'd2,   1'b0, 1'b1));
        // eight ticks walk the step counter through sweep and envelope steps
        repeat (8)
            send_request(make_request(CMD_TICK, 4'd0, 8'd0, 2'd0, 9'd0, 1'b0, 1'b0));
        send_request(make_request(CMD_READ, 4'd0, 8'd0, 2'd0, 9'd0, 1'b0, 1'b0));
        // master off clears status but not the counters; ticks keep running
        send_request(make_request(CMD_WRITE, REG_MASTER, 8'h7F, 2'd0, 9'd0, 1'b0, 1'b0));
        send_request(make_request(CMD_TICK, 4'd0, 8'd0, 2'd0, 9'd0, 1'b0, 1'b0));
        send_request(make_request(CMD_WRITE, REG_MASTER, 8'hFF, 2'd0, 9'd0, 1'b0, 1'b0));
    endtask

    // bulk random traffic, pacing reshuffled every couple of hundred requests
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) begin
                // the first stretch runs without any idling on either side
                tx_gap_max = (i == 0) ? 0 : $urandom_range(0, 3) * 4;
                rx_mode    = (i == 0) ? 0 : $urandom_range(0, 3);
            end
            send_request(random_request());
        end
    endtask

    // receiver holds off long enough for the block to fill and stall s_
    task automatic test_output_backpressure();
        tx_gap_max  = 0;
        rx_mode     = 0;
        rx_hold_off = 300;
        for (int i = 0; i < 80; i++)
            send_request(random_request());
        // sender waits for every outstanding result before resuming
        wait_all_results();
        rx_mode    = 1;
        tx_gap_max = 6;
        for (int i = 0; i < 80; i++)
            send_request(random_request());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_length_counters();
        test_random_traffic(1400);
        test_output_backpressure();

        wait_all_results();
        repeat (4) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** sound_frame_sequencer_control: PASSED **");
        end else begin
            $display("** sound_frame_sequencer_control: FAILED **");
        end
        $finish;
    end

endmodule
